/* rtl/adrp_pkg.sv */
`timescale 1ns / 1ps

package adrp_pkg;

    localparam int MAX_CHARS_DEFAULT = 16;

    // Classified item queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] MIN_RESET = 32'h0000_0001;
    localparam logic [31:0] MAX_RESET = 32'h0000_0010;

    // Magnitude limits for a positive and a negative line
    localparam logic [35:0] LIMIT_POS = 36'h0_7FFF_FFFF;
    localparam logic [35:0] LIMIT_NEG = 36'h0_8000_0000;

    localparam int CFG_ADDR_W = 3;
    localparam logic REG_MIN_VALUE = 1'b0;
    localparam logic REG_MAX_VALUE = 1'b1;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        KIND_END   = 2'd0,
        KIND_MINUS = 2'd1,
        KIND_DIGIT = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic        echo_valid;
        logic [7:0]  echo_byte;
        logic        line_done;
        logic        number_ok;
        logic [31:0] number_value;
    } result_t;

endpackage

/* rtl/adrp_front.sv */
`timescale 1ns / 1ps

module adrp_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          rx_byte,
    input  logic                queue_full,
    output logic                push,
    output adrp_pkg::item_t     item
);

    always_comb begin
        item.data = rx_byte;
        if (rx_byte == adrp_pkg::CH_LF || rx_byte == adrp_pkg::CH_CR) begin
            item.kind = adrp_pkg::KIND_END;
        end else if (rx_byte == adrp_pkg::CH_MINUS) begin
            item.kind = adrp_pkg::KIND_MINUS;
        end else if (rx_byte >= adrp_pkg::CH_ZERO && rx_byte <= adrp_pkg::CH_NINE) begin
            item.kind = adrp_pkg::KIND_DIGIT;
        end else begin
            item.kind = adrp_pkg::KIND_OTHER;
        end
    end

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

endmodule

/* rtl/adrp_fifo.sv */
`timescale 1ns / 1ps

module adrp_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  adrp_pkg::item_t     push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output adrp_pkg::item_t     head_item
);

    localparam int DEPTH = adrp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    adrp_pkg::item_t    store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_item  = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/adrp_back.sv */
`timescale 1ns / 1ps

module adrp_back #(
    parameter int MAX_CHARS = adrp_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  adrp_pkg::item_t     head_item,
    output logic                pop,
    input  logic [31:0]         min_value,
    input  logic [31:0]         max_value,
    output logic                out_valid,
    input  logic                out_ready,
    output adrp_pkg::result_t   result
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

    logic [31:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic               all_valid_reg, all_valid_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               in_line_reg, in_line_next;
    logic               out_valid_reg, out_valid_next;
    adrp_pkg::result_t  result_reg, result_next;

    logic signed [32:0] value_s;
    logic               ok;
    logic [35:0]        mag_x10;
    logic [35:0]        limit;

    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb begin
        value_s = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        ok = all_valid_reg
            && (value_s >= $signed({min_value[31], min_value}))
            && (value_s <= $signed({max_value[31], max_value}));
        mag_x10 = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                + {32'b0, head_item.data[3:0]};
        limit = neg_reg ? adrp_pkg::LIMIT_NEG : adrp_pkg::LIMIT_POS;
    end

    always_comb begin
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        all_valid_next = all_valid_reg;
        cnt_next       = cnt_reg;
        in_line_next   = in_line_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (pop) begin
            out_valid_next = 1'b1;
            result_next    = '0;
            if (head_item.kind == adrp_pkg::KIND_END) begin
                // line end outside a line gives an all-zero result
                if (in_line_reg) begin
                    result_next.echo_valid   = 1'b1;
                    result_next.echo_byte    = adrp_pkg::CH_LF;
                    result_next.line_done    = 1'b1;
                    result_next.number_ok    = ok;
                    result_next.number_value = ok ? value_s[31:0] : '1;
                    mag_next       = '0;
                    neg_next       = 1'b0;
                    all_valid_next = 1'b1;
                    cnt_next       = '0;
                    in_line_next   = 1'b0;
                end
            end else begin
                result_next.echo_valid = 1'b1;
                result_next.echo_byte  = head_item.data;
                in_line_next           = 1'b1;
                if (cnt_reg >= CNT_MAX) begin
                    all_valid_next = 1'b0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                    case (head_item.kind)
                        adrp_pkg::KIND_MINUS: begin
                            if (cnt_reg == '0) begin
                                neg_next = 1'b1;
                            end else begin
                                all_valid_next = 1'b0;
                            end
                        end
                        adrp_pkg::KIND_DIGIT: begin
                            // overflowing digit keeps the old magnitude
                            if (mag_x10 > limit) begin
                                all_valid_next = 1'b0;
                            end else begin
                                mag_next = mag_x10[31:0];
                            end
                        end
                        default: begin
                            all_valid_next = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            all_valid_reg <= 1'b1;
            cnt_reg       <= '0;
            in_line_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            all_valid_reg <= all_valid_next;
            cnt_reg       <= cnt_next;
            in_line_reg   <= in_line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

endmodule

/* rtl/ascii_signed_decimal_range_parser_top.sv */
`timescale 1ns / 1ps

// Channel   Dir  tdata / data                                  tuser
// s_axis    in   [7:0] rx_byte                                 -
// m_axis    out  [7:0] echo_byte, [8] number_ok,               [0] echo_valid,
//                [40:9] number_value, [47:41] zero             [1] line_done
// apb       in   0x0 min_value, 0x4 max_value (32 bit, signed) -
//
// One item per cycle sustained unless the output stalls; every input item gives
// exactly one result item. The classified item is written to a 4-entry queue,
// then the parse step updates the line state and loads the output register.
// Either side may stall on its own; the queue absorbs up to four items.
// aresetn is synchronous, active low; min_value resets to 1, max_value to 16.

module ascii_signed_decimal_range_parser_top #(
    parameter int MAX_CHARS = adrp_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [adrp_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] echo_byte, [8] number_ok, [40:9] number_value, [47:41] zero
    output logic [adrp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [adrp_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] echo_valid, [1] line_done

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [adrp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [31:0]        min_value_reg;
    logic [31:0]        max_value_reg;
    logic               cfg_write;

    adrp_pkg::item_t    front_item;
    adrp_pkg::item_t    head_item;
    logic               push;
    logic               queue_full;
    logic               head_valid;
    logic               pop;
    adrp_pkg::result_t  result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == adrp_pkg::REG_MAX_VALUE) ? max_value_reg : min_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_value_reg <= adrp_pkg::MIN_RESET;
            max_value_reg <= adrp_pkg::MAX_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == adrp_pkg::REG_MIN_VALUE) begin
                min_value_reg <= pwdata;
            end else begin
                max_value_reg <= pwdata;
            end
        end
    end

    adrp_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .rx_byte    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .item       (front_item)
    );

    adrp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (front_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    adrp_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .min_value  (min_value_reg),
        .max_value  (max_value_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

    assign m_tdata = {7'b0, result.number_value, result.number_ok, result.echo_byte};
    assign m_tuser = {result.line_done, result.echo_valid};

endmodule

/* rtl/adrp_checker.sv */
`timescale 1ns / 1ps

module adrp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [adrp_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [adrp_pkg::M_TUSER_W-1:0]  m_tuser
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a line report always echoes LF
    a_done_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata[7:0] == adrp_pkg::CH_LF)
        else $error("line report without LF echo");

    a_fail_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] && !m_tdata[8] |-> m_tdata[40:9] == 32'hFFFF_FFFF)
        else $error("failed line does not report -1");

    a_no_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> !m_tdata[8] && m_tdata[40:9] == 32'h0)
        else $error("number fields set without a line report");

endmodule

bind ascii_signed_decimal_range_parser_top adrp_checker u_adrp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* bench/ascii_signed_decimal_range_parser_top_test.sv */
`timescale 1ns / 1ps

module ascii_signed_decimal_range_parser_top_test;

    import adrp_pkg::*;

    localparam int LINE_LIMIT = MAX_CHARS_DEFAULT;
    localparam int PHASES = 7;
    localparam int ITEMS_PER_PHASE = 236;

    localparam result_t LINE_SKIPPED  = '0;
    localparam result_t LINE_REJECTED = '{1'b1, CH_LF, 1'b1, 1'b0, 32'hFFFF_FFFF};

    typedef struct {
        string   text;
        bit      pinned;   // tail result typed in below
        result_t tail;
    } row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    ascii_signed_decimal_range_parser_top #(
        .MAX_CHARS(LINE_LIMIT)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #4 aclk = ~aclk;

    // Mirror of the range registers and the line being parsed
    int          range_lo = int'(MIN_RESET);
    int          range_hi = int'(MAX_RESET);
    logic [31:0] acc_mag = '0;
    bit          acc_neg = 1'b0;
    bit          acc_clean = 1'b1;
    int          acc_chars = 0;
    bit          acc_open = 1'b0;

    result_t     pending_results[$];
    logic [7:0]  line_bytes[$];

    int send_idle_pct = 32;
    int recv_idle_pct = 54;
    int errors = 0;
    int bytes_sent = 0;
    int lines_seen = 0;
    int lines_ok = 0;

    result_t seen;
    result_t want;

    row_t directed_rows [8] = '{
        '{"\r\n",         1'b1, LINE_SKIPPED},
        '{"16\r",         1'b1, '{1'b1, CH_LF, 1'b1, 1'b1, 32'd16}},
        '{"17\n",         1'b1, LINE_REJECTED},
        '{"1\n",          1'b1, '{1'b1, CH_LF, 1'b1, 1'b1, 32'd1}},
        '{"-\n",          1'b1, LINE_REJECTED},
        '{":\377/\n",     1'b1, LINE_REJECTED},
        '{"5-\n",         1'b1, LINE_REJECTED},
        '{"2147483648\n", 1'b1, LINE_REJECTED}
    };

    function automatic string show(result_t r);
        return $sformatf("echo=%0b/%02h done=%0b ok=%0b value=%0d",
                         r.echo_valid, r.echo_byte, r.line_done, r.number_ok,
                         $signed(r.number_value));
    endfunction

    function void clear_line();
        acc_mag = '0;
        acc_neg = 1'b0;
        acc_clean = 1'b1;
        acc_chars = 0;
        acc_open = 1'b0;
    endfunction

    function result_t parse_byte(input logic [7:0] b);
        result_t r;
        longint  v;
        longint  nxt;
        longint  cap;
        bit      ok;
        r = '0;
        if (b == CH_LF || b == CH_CR) begin
            if (acc_open) begin
                v = longint'(acc_mag);
                if (acc_neg)
                    v = -v;
                ok = acc_clean && v >= range_lo && v <= range_hi;
                r = '{1'b1, CH_LF, 1'b1, ok, ok ? v[31:0] : 32'hFFFF_FFFF};
                clear_line();
            end
            return r;
        end
        r.echo_valid = 1'b1;
        r.echo_byte = b;
        if (acc_chars >= LINE_LIMIT) begin
            acc_clean = 1'b0;
        end else begin
            acc_chars++;
            if (acc_chars == 1 && b == CH_MINUS) begin
                acc_neg = 1'b1;
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
                cap = acc_neg ? longint'(LIMIT_NEG) : longint'(LIMIT_POS);
                nxt = longint'(acc_mag) * 10 + b[3:0];
                if (nxt > cap)
                    acc_clean = 1'b0;
                else
                    acc_mag = nxt[31:0];
            end else begin
                acc_clean = 1'b0;
            end
        end
        acc_open = 1'b1;
        return r;
    endfunction

    function void note_error(string what, result_t exp_r, result_t got_r);
        errors++;
        if (errors <= 10)
            $display("%0t %s: expected %s, got %s", $realtime, what, show(exp_r), show(got_r));
    endfunction

    // Called at a falling edge; leaves s_tvalid high after acceptance
    task send_byte(input logic [7:0] b, input bit pinned, input result_t tail);
        result_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        r = parse_byte(b);
        pending_results.push_back(pinned ? tail : r);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task send_line();
        while (line_bytes.size() != 0)
            send_byte(line_bytes.pop_front(), 1'b0, LINE_SKIPPED);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // APB tasks leave the bus selected; the caller returns it to idle
    task apb_write(input logic idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_MIN_VALUE)
            range_lo = value;
        else
            range_hi = value;
        @(negedge aclk);
    endtask

    task apb_check(input logic idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== value) begin
            errors++;
            if (errors <= 10)
                $display("%0t register %0d readback: expected %08h, got %08h",
                         $realtime, idx, value, prdata);
        end
        @(negedge aclk);
    endtask

    task set_range(input int lo, input int hi);
        apb_write(REG_MIN_VALUE, lo);
        apb_write(REG_MAX_VALUE, hi);
        apb_check(REG_MIN_VALUE, lo);
        apb_check(REG_MAX_VALUE, hi);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    function void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endfunction

    function void push_number(longint v);
        longint mag;
        int     zeros;
        mag = (v < 0) ? -v : v;
        zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
        if (v < 0)
            line_bytes.push_back(CH_MINUS);
        repeat (zeros) line_bytes.push_back(CH_ZERO);
        push_text($sformatf("%0d", mag));
    endfunction

    function longint pick_value();
        longint span;
        longint r;
        span = longint'(range_hi) - longint'(range_lo) + 1;
        r = longint'($urandom);
        case ($urandom_range(0, 5))
            0, 1:    return (span > 0) ? range_lo + r % span : longint'(int'($urandom));
            2:       return longint'(range_lo) + $urandom_range(0, 2) - 1;
            3:       return longint'(range_hi) + $urandom_range(0, 2) - 1;
            4:       return longint'(int'($urandom));
            default: return longint'($urandom_range(0, 80)) - 40;
        endcase
    endfunction

    // One random line: mostly well-formed numbers, the rest edge and junk text
    function void build_line();
        int kind;
        int len;
        int pos;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            push_number(pick_value());
        end else if (kind < 55) begin
            // long runs of zeros straddle the character limit
            len = $urandom_range(LINE_LIMIT - 2, LINE_LIMIT + 4);
            if ($urandom_range(0, 1))
                line_bytes.push_back(CH_MINUS);
            repeat (len - 2) line_bytes.push_back(CH_ZERO);
            repeat (2) line_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end else if (kind < 65) begin
            if ($urandom_range(0, 1))
                line_bytes.push_back(CH_MINUS);
            repeat ($urandom_range(1, 12))
                line_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end else if (kind < 75) begin
            repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 85) begin
            push_number(longint'($urandom_range(0, 99999)) * ($urandom_range(0, 1) ? -1 : 1));
            pos = $urandom_range(0, line_bytes.size() - 1);
            case ($urandom_range(0, 3))
                0:       line_bytes[pos] = CH_MINUS;
                1:       line_bytes[pos] = 8'(CH_NINE + 1);
                2:       line_bytes[pos] = 8'(CH_ZERO - 1);
                default: line_bytes[pos] = 8'($urandom_range(0, 255));
            endcase
        end else if (kind < 92) begin
            line_bytes.push_back(CH_MINUS);
            if ($urandom_range(0, 1))
                line_bytes.push_back($urandom_range(0, 1) ? CH_MINUS : 8'h41);
        end
        line_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        if ($urandom_range(0, 3) == 0)
            line_bytes.push_back(CH_LF);
    endfunction

    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.echo_valid = m_tuser[0];
            seen.line_done = m_tuser[1];
            seen.echo_byte = m_tdata[7:0];
            seen.number_ok = m_tdata[8];
            seen.number_value = m_tdata[40:9];
            if (seen.line_done) begin
                lines_seen++;
                if (seen.number_ok)
                    lines_ok++;
            end
            if (pending_results.size() == 0) begin
                note_error("unexpected item", '0, seen);
            end else begin
                want = pending_results.pop_front();
                if (seen !== want)
                    note_error("mismatch", want, seen);
                else if (m_tdata[47:41] !== '0)
                    note_error("nonzero pad bits", want, seen);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            for (int k = 0; k < directed_rows[i].text.len(); k++)
                send_byte(directed_rows[i].text[k],
                          directed_rows[i].pinned && k == directed_rows[i].text.len() - 1,
                          directed_rows[i].tail);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1: set_range(int'(32'h8000_0000), int'(32'h7FFF_FFFF));
                    2: set_range(-1000, 1000);
                    3: set_range(7, 7);
                    4: set_range(100, -100);   // empty range
                    5: set_range(int'($urandom), int'($urandom));
                    default: set_range(int'(32'h8000_0000), -1);
                endcase
            end
            if (p >= 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (p >= 2) begin
                send_idle_pct = 54;
                recv_idle_pct = 32;
            end
            for (int target = bytes_sent + ITEMS_PER_PHASE; bytes_sent < target; ) begin
                build_line();
                send_line();
            end
        end

        drain();
        repeat (10) @(negedge aclk);
        $display("Sent %0d bytes under %0d range settings, three stall patterns.",
                 bytes_sent, PHASES);
        $display("Lines reported: %0d (%0d accepted), mismatches: %0d.",
                 lines_seen, lines_ok, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
